// ----- design/hpe_pkg.sv -----
// Shared types, constants and register indexes for the Horner polynomial evaluator.
`default_nettype none

package hpe_pkg;

    // Word format
    localparam int WORD_W        = 32;
    localparam int DEG_W         = 3;
    localparam int NUM_COEFFS    = 7;
    localparam int CFG_IDX_W     = 4;

    // Defaults for the top-level parameters
    localparam int MAX_DEGREE_DEF = 6;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_0 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_6 = 4'd7;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [NUM_COEFFS-1:0][WORD_W-1:0] coeff_arr_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [DEG_W-1:0] degree;
        coeff_arr_t       coeffs;
    } cfg_t;

    // One word in flight between Horner steps
    typedef struct packed {
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] acc;
        logic [DEG_W-1:0]         degree;
        logic                     ovf;
    } stage_t;

endpackage

`default_nettype wire

// ----- design/hpe_cfg.sv -----
// Configuration register file: degree and the seven coefficients.
`default_nettype none

module hpe_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [hpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [hpe_pkg::WORD_W-1:0]      cfg_data,
    output hpe_pkg::cfg_t                        cfg
);

    logic [hpe_pkg::DEG_W-1:0] degree_reg;
    hpe_pkg::coeff_arr_t       coeffs_reg;
    logic                      coeff_hit;
    logic [hpe_pkg::DEG_W-1:0] coeff_sel;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Decode the coefficient slot
    assign coeff_hit = (cfg_index >= hpe_pkg::REG_COEFF_0) &&
                       (cfg_index <= hpe_pkg::REG_COEFF_6);
    assign coeff_sel = hpe_pkg::DEG_W'(cfg_index - hpe_pkg::REG_COEFF_0);

    // Register writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= '0;
            coeffs_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == hpe_pkg::REG_DEGREE) begin
                degree_reg <= cfg_data[hpe_pkg::DEG_W-1:0];
            end else if (coeff_hit) begin
                coeffs_reg[coeff_sel] <= cfg_data;
            end
        end
    end

    assign cfg.degree = degree_reg;
    assign cfg.coeffs = coeffs_reg;

endmodule

`default_nettype wire

// ----- design/hpe_step.sv -----
// One Horner step: a multiply stage, then a shift, add and saturate stage.
`default_nettype none

module hpe_step #(
    parameter int STEP_K    = 0,
    parameter int FRAC_BITS = hpe_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire hpe_pkg::stage_t             in_data,
    input  wire logic [hpe_pkg::WORD_W-1:0]  coeff,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output hpe_pkg::stage_t                  out_data
);

    localparam int W  = hpe_pkg::WORD_W;
    localparam int PW = 2 * W;

    logic                   a_valid_reg;
    hpe_pkg::stage_t        a_data_reg;
    logic signed [PW-1:0]   a_prod_reg;
    logic signed [PW-1:0]   a_prod_next;
    logic                   b_valid_reg;
    hpe_pkg::stage_t        b_data_reg;
    hpe_pkg::stage_t        b_data_next;
    logic                   b_ready;
    logic                   active;
    logic signed [PW:0]     sum;
    logic                   sat_hi;
    logic                   sat_lo;

    // Per-stage flow control
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || b_ready;

    // Full product of accumulator and x (32 x 32 signed)
    assign a_prod_next = $signed(in_data.acc) * $signed(in_data.x);

    // This step only applies below the degree
    assign active = (hpe_pkg::DEG_W'(STEP_K) < a_data_reg.degree);

    // Floor shift, add coefficient, clamp to a word
    always_comb begin
        sum    = (PW+1)'(a_prod_reg >>> FRAC_BITS) + (PW+1)'($signed(coeff));
        sat_hi = !sum[PW] && (|sum[PW-1:W-1]);
        sat_lo = sum[PW] && !(&sum[PW-1:W-1]);
        b_data_next = a_data_reg;
        if (active) begin
            if (sat_hi) begin
                b_data_next.acc = {1'b0, {(W-1){1'b1}}};
            end else if (sat_lo) begin
                b_data_next.acc = {1'b1, {(W-1){1'b0}}};
            end else begin
                b_data_next.acc = sum[W-1:0];
            end
            b_data_next.ovf = a_data_reg.ovf | sat_hi | sat_lo;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            a_data_reg <= in_data;
            a_prod_reg <= a_prod_next;
        end
        if (b_ready && a_valid_reg) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

// ----- design/polynomial_evaluate_horner_top.sv -----
// Top level of the pipelined Horner polynomial evaluator.
//
// Usage:
//   The s_ channel takes one x word (signed fixed point, FRAC_BITS fraction
//   bits) per accepted transfer; the m_ channel returns y and an overflow
//   flag for each, in order. The cfg channel writes the degree (index 0)
//   and coefficients 0..6 (indexes 1..7); other indexes are dropped.
//   Write configuration only while the pipeline is empty.
//   The pipeline is one entry stage that picks the top coefficient, then
//   a multiply stage and a shift/add/saturate stage per Horner step.
//   Steps above the degree pass the word through unchanged. Throughput is
//   one word per cycle while m_ready keeps the pipeline moving.
//   Each stage holds its word while the next is full, so a stall on m_ready
//   fills the pipeline from the back and then drops s_ready; nothing is
//   lost or repeated. Reset empties the pipeline and clears the degree and
//   all coefficients to zero.
`default_nettype none

module polynomial_evaluate_horner_top #(
    parameter int MAX_DEGREE = hpe_pkg::MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = hpe_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [hpe_pkg::WORD_W-1:0] s_x_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [hpe_pkg::WORD_W-1:0]    m_y_value,
    output logic                                 m_overflow,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [hpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [hpe_pkg::WORD_W-1:0]      cfg_data
);

    hpe_pkg::cfg_t             cfg;
    logic [hpe_pkg::DEG_W-1:0] deg_eff;
    logic                      ent_valid_reg;
    hpe_pkg::stage_t           ent_data_reg;
    hpe_pkg::stage_t           ent_data_next;
    logic                      ent_ready;

    logic            chain_valid [MAX_DEGREE+1];
    logic            chain_ready [MAX_DEGREE+1];
    hpe_pkg::stage_t chain_data  [MAX_DEGREE+1];

    // Configuration registers
    hpe_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Degree clamped to what the pipeline holds
    assign deg_eff = (cfg.degree > hpe_pkg::DEG_W'(MAX_DEGREE)) ?
                     hpe_pkg::DEG_W'(MAX_DEGREE) : cfg.degree;

    // Entry stage: accumulator starts at the top coefficient
    always_comb begin
        ent_data_next.x      = s_x_value;
        ent_data_next.acc    = cfg.coeffs[deg_eff];
        ent_data_next.degree = deg_eff;
        ent_data_next.ovf    = 1'b0;
    end

    assign ent_ready = !ent_valid_reg || chain_ready[0];
    assign s_ready   = ent_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= 1'b0;
        end else if (ent_ready) begin
            ent_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ent_ready && s_valid) begin
            ent_data_reg <= ent_data_next;
        end
    end

    assign chain_valid[0] = ent_valid_reg;
    assign chain_data[0]  = ent_data_reg;

    // Horner steps, highest power first
    for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_step
        hpe_step #(
            .STEP_K    (MAX_DEGREE - 1 - j),
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[j]),
            .in_ready  (chain_ready[j]),
            .in_data   (chain_data[j]),
            .coeff     (cfg.coeffs[MAX_DEGREE - 1 - j]),
            .out_valid (chain_valid[j+1]),
            .out_ready (chain_ready[j+1]),
            .out_data  (chain_data[j+1])
        );
    end

    // Output channel from the last step's register
    assign chain_ready[MAX_DEGREE] = m_ready;
    assign m_valid    = chain_valid[MAX_DEGREE];
    assign m_y_value  = chain_data[MAX_DEGREE].acc;
    assign m_overflow = chain_data[MAX_DEGREE].ovf;

`ifndef SYNTHESIS
    // Input backs up only when the output is blocked
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without an output stall");

    // Pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result word valid right after reset");
`endif

endmodule

`default_nettype wire

// ----- dv/polynomial_evaluate_horner_top_tb.sv -----
// Self-checking testbench for the pipelined Horner polynomial evaluator.
`timescale 1ns / 100ps

module polynomial_evaluate_horner_top_tb;

    localparam int MAX_DEGREE   = hpe_pkg::MAX_DEGREE_DEF;
    localparam int FRAC_BITS    = hpe_pkg::FRAC_BITS_DEF;
    localparam int PIPE_LATENCY = 1 + 2 * MAX_DEGREE;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_LIMIT   = 4000;
    localparam int NUM_PHASES   = 16;
    localparam int PHASE_WORDS  = 100;
    localparam int FLOOD_WORDS  = 48;

    localparam logic [hpe_pkg::CFG_IDX_W-1:0] CFG_IDX_MAX = {hpe_pkg::CFG_IDX_W{1'b1}};

    localparam hpe_pkg::word_t Q_ONE    = 32'sh0001_0000;
    localparam hpe_pkg::word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam hpe_pkg::word_t WORD_MIN = 32'sh8000_0000;
    localparam longint SAT_HI  = 64'sd2147483647;
    localparam longint SAT_LO  = -64'sd2147483648;

    typedef struct packed {
        logic signed [hpe_pkg::WORD_W-1:0] y;
        logic                              ovf;
    } poly_result_t;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_CADENCE} rx_mode_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    hpe_pkg::word_t                s_x_value;
    logic                          m_valid;
    logic                          m_ready;
    hpe_pkg::word_t                m_y_value;
    logic                          m_overflow;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [hpe_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hpe_pkg::WORD_W-1:0]    cfg_data;

    // Shadow copy of the register file used by the predictor
    logic [hpe_pkg::DEG_W-1:0] shadow_degree = '0;
    hpe_pkg::coeff_arr_t       shadow_coeffs = '0;

    poly_result_t predicted_q[$];

    bit       hold_req       = 1'b0;
    int       err_count      = 0;
    int       n_x_sent       = 0;
    int       n_y_checked    = 0;
    int       n_overflow_set = 0;
    int       n_cfg_writes   = 0;
    int       n_input_stalls = 0;
    int       idle_cycles    = 0;
    logic [7:0] degrees_written = '0;

    polynomial_evaluate_horner_top #(
        .MAX_DEGREE(MAX_DEGREE),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_x_value (s_x_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_y_value (m_y_value),
        .m_overflow(m_overflow),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Horner evaluation with per-step floor shift and 32-bit saturation
    function automatic poly_result_t horner_eval(input hpe_pkg::word_t x);
        int           top;
        int           k;
        longint       acc;
        longint       sum;
        poly_result_t r;
        top   = (shadow_degree > MAX_DEGREE) ? MAX_DEGREE : int'(shadow_degree);
        acc   = longint'($signed(shadow_coeffs[top]));
        r.ovf = 1'b0;
        for (k = top - 1; k >= 0; k--) begin
            sum = ((acc * longint'(x)) >>> FRAC_BITS)
                  + longint'($signed(shadow_coeffs[k]));
            if (sum > SAT_HI) begin
                acc   = SAT_HI;
                r.ovf = 1'b1;
            end else if (sum < SAT_LO) begin
                acc   = SAT_LO;
                r.ovf = 1'b1;
            end else begin
                acc = sum;
            end
        end
        r.y = acc[hpe_pkg::WORD_W-1:0];
        return r;
    endfunction

    // Sample points: full range, small magnitudes, the corners, and plus or minus one
    function automatic hpe_pkg::word_t pick_x();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            return $urandom();
        end else if (sel < 8) begin
            return $urandom_range(0, 32'h6_0000) - 32'sh3_0000;
        end else if (sel == 8) begin
            case ($urandom_range(0, 4))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return '0;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end else begin
            return ($urandom_range(0, 1) != 0) ? Q_ONE : -Q_ONE;
        end
    endfunction

    function automatic hpe_pkg::word_t pick_coeff();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            return $urandom();
        end else if (sel < 7) begin
            return $urandom_range(0, 32'h8_0000) - 32'sh4_0000;
        end else if (sel == 7) begin
            case ($urandom_range(0, 3))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return '0;
                default: return -32'sd1;
            endcase
        end else begin
            return $urandom_range(0, 32'hFFFF);
        end
    endfunction

    // One x word on the input channel; valid stays up for the caller to reuse
    task automatic send_x(input hpe_pkg::word_t x);
        s_valid   <= 1'b1;
        s_x_value <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted_q.push_back(horner_eval(x));
        n_x_sent++;
    endtask

    // One register write; the caller drops cfg_valid after the batch
    task automatic cfg_write(input logic [hpe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hpe_pkg::WORD_W-1:0]    data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == hpe_pkg::REG_DEGREE) begin
            shadow_degree = data[hpe_pkg::DEG_W-1:0];
            degrees_written[data[hpe_pkg::DEG_W-1:0]] = 1'b1;
        end else if (idx >= hpe_pkg::REG_COEFF_0 && idx <= hpe_pkg::REG_COEFF_6) begin
            shadow_coeffs[idx - hpe_pkg::REG_COEFF_0] = data;
        end
        n_cfg_writes++;
    endtask

    task automatic program_poly(input logic [hpe_pkg::WORD_W-1:0] deg_word,
                                input hpe_pkg::coeff_arr_t        c);
        int k;
        cfg_write(hpe_pkg::REG_DEGREE, deg_word);
        for (k = 0; k < hpe_pkg::NUM_COEFFS; k++) begin
            cfg_write(hpe_pkg::CFG_IDX_W'(hpe_pkg::REG_COEFF_0 + k), c[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        while (predicted_q.size() != 0) @(posedge aclk);
    endtask

    // Random words in bursts; gaps only when asked for
    task automatic send_stream(input int count, input bit with_gaps);
        int burst_left;
        int gap;
        int i;
        burst_left = $urandom_range(1, 32);
        for (i = 0; i < count; i++) begin
            send_x(pick_x());
            burst_left--;
            if (with_gaps && burst_left == 0 && i != count - 1) begin
                burst_left = $urandom_range(1, 32);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    endtask

    // Registers at their reset values: every x gives zero
    task automatic test_reset_state();
        send_x(WORD_MAX);
        send_x(WORD_MIN);
        send_x(Q_ONE);
        drain();
    endtask

    // Degree zero returns the constant term; higher coefficients ignored
    task automatic test_degree_zero();
        hpe_pkg::coeff_arr_t c;
        c = {hpe_pkg::NUM_COEFFS{WORD_MAX}};
        c[0] = WORD_MIN;
        program_poly(32'd0, c);
        send_x(WORD_MAX);
        send_x('0);
        drain();
    endtask

    // Full degree with moderate coefficients over the corners of x
    task automatic test_full_degree();
        hpe_pkg::coeff_arr_t c;
        int k;
        for (k = 0; k < hpe_pkg::NUM_COEFFS; k++) begin
            c[k] = ((k % 2) != 0) ? -((k + 1) * Q_ONE / 2) : (k + 1) * Q_ONE / 2;
        end
        // upper data bits are set; only the low bits reach the degree
        program_poly(32'hFFFF_FFF8 | MAX_DEGREE, c);
        send_x('0);
        send_x(32'sd1);
        send_x(-32'sd1);
        send_x(Q_ONE);
        send_x(-Q_ONE);
        send_x(WORD_MAX);
        send_x(WORD_MIN);
        drain();
    endtask

    // Clamping at both rails
    task automatic test_saturation();
        program_poly(MAX_DEGREE, {hpe_pkg::NUM_COEFFS{WORD_MAX}});
        send_x(WORD_MAX);
        send_x(WORD_MIN);
        drain();
        program_poly(MAX_DEGREE, {hpe_pkg::NUM_COEFFS{WORD_MIN}});
        send_x(WORD_MAX);
        drain();
    endtask

    // Degree field above the maximum is treated as the maximum
    task automatic test_degree_clamp();
        cfg_write(hpe_pkg::REG_DEGREE, 32'd7);
        cfg_write(hpe_pkg::REG_COEFF_6, Q_ONE);
        cfg_valid <= 1'b0;
        send_x(Q_ONE);
        send_x(-2 * Q_ONE);
        drain();
    endtask

    // Writes past the last coefficient change nothing
    task automatic test_ignored_index();
        cfg_write(hpe_pkg::CFG_IDX_W'(hpe_pkg::REG_COEFF_6 + 1), 32'hDEAD_BEEF);
        cfg_write(CFG_IDX_MAX, 32'h1234_5678);
        cfg_valid <= 1'b0;
        send_x(Q_ONE / 2);
        send_x(-3 * Q_ONE);
        drain();
    endtask

    // Receiver holds off while words keep coming, so s_ready must drop
    task automatic test_backpressure();
        hold_req = 1'b1;
        send_stream(FLOOD_WORDS, 1'b0);
        drain();
    endtask

    // Random register settings, each followed by a stream of random x words
    task automatic test_random_configs();
        int ph;
        int k;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            cfg_write(hpe_pkg::REG_DEGREE, ($urandom() & ~32'h7) | $urandom_range(0, 7));
            for (k = 0; k < hpe_pkg::NUM_COEFFS; k++) begin
                if ($urandom_range(0, 4) != 0) begin
                    cfg_write(hpe_pkg::CFG_IDX_W'(hpe_pkg::REG_COEFF_0 + k), pick_coeff());
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                cfg_write(hpe_pkg::CFG_IDX_W'($urandom_range(hpe_pkg::REG_COEFF_6 + 1,
                                                             CFG_IDX_MAX)),
                          $urandom());
            end
            cfg_valid <= 1'b0;
            send_stream(PHASE_WORDS, (ph % 4) != 3);
            drain();
        end
    endtask

    // Receiver stall pattern, plus the long hold-off on request
    initial begin : rx_stall_pattern
        rx_mode_t mode;
        int       stretch_left;
        int       k;
        m_ready      = 1'b0;
        mode         = RX_OPEN;
        stretch_left = 0;
        k            = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    mode         = rx_mode_t'($urandom_range(0, 3));
                    stretch_left = $urandom_range(16, 160);
                    k            = 0;
                end
                stretch_left--;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 9) < 7);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 9) < 3);
                    default:   m_ready <= ((k % 5) < 3);
                endcase
                k++;
            end
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge aclk) begin : check_results
        poly_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_q.size() == 0) begin
                $error("unexpected result word: y_value=%h overflow=%b",
                       m_y_value, m_overflow);
                err_count++;
            end else begin
                want = predicted_q.pop_front();
                n_y_checked++;
                if (m_overflow) n_overflow_set++;
                if (m_y_value !== want.y) begin
                    $error("y_value: expected %h, got %h", want.y, m_y_value);
                    err_count++;
                end
                if (m_overflow !== want.ovf) begin
                    $error("overflow: expected %b, got %b", want.ovf, m_overflow);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (aresetn && s_valid && !s_ready) n_input_stalls++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, predicted_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_x_value = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_degree_zero();
        test_full_degree();
        test_saturation();
        test_degree_clamp();
        test_ignored_index();
        test_backpressure();
        test_random_configs();

        // let any stray result surface before the verdict
        repeat (PIPE_LATENCY + 8) @(posedge aclk);

        $display("Sent %0d x words under %0d register writes (degree values written: %b).",
                 n_x_sent, n_cfg_writes, degrees_written);
        $display("Checked %0d results, %0d saturated; input held off for %0d cycles.",
                 n_y_checked, n_overflow_set, n_input_stalls);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/hpe_pkg.sv
design/hpe_cfg.sv
design/hpe_step.sv
design/polynomial_evaluate_horner_top.sv
dv/polynomial_evaluate_horner_top_tb.sv
